/* rtl/msig_pkg.sv */
// ----------------------------------------------------------------------------
// msig_pkg
// Shared types, codes and helper functions for the masked signature sniffer.
// ----------------------------------------------------------------------------
package msig_pkg;

  // default sizes
  localparam int SLOTS_DEF           = 16;
  localparam int MAX_PATTERN_LEN_DEF = 16;
  localparam int FORMATS_DEF         = 16;

  // xpm comment length and the score that ends the ranking
  localparam int         XPM_LEN       = 9;
  localparam logic [6:0] PERFECT_SCORE = 7'd100;

  // input item modes
  localparam logic [1:0] MODE_PAT  = 2'd0;
  localparam logic [1:0] MODE_HDR  = 2'd1;
  localparam logic [1:0] MODE_DATA = 2'd2;

  // per-byte mask codes
  localparam logic [2:0] MASK_EQ      = 3'd0;
  localparam logic [2:0] MASK_NE      = 3'd1;
  localparam logic [2:0] MASK_ZERO    = 3'd2;
  localparam logic [2:0] MASK_NONZERO = 3'd3;

  // one stored pattern byte
  typedef struct packed {
    logic [2:0] code;
    logic [7:0] value;
  } pat_entry_t;

  // slot header without the length, whose width follows the pattern size
  typedef struct packed {
    logic       en;
    logic [3:0] fmt;
    logic [6:0] rel;
    logic       anch;
  } slot_hdr_t;

  // control from the sequencer to the score store
  typedef struct packed {
    logic       clear;
    logic       rec;
    logic [3:0] rec_fmt;
    logic [6:0] rec_rel;
    logic       rank_rd;
  } score_ctl_t;

  // one masked byte compare
  function automatic logic byte_ok(pat_entry_t p, logic [7:0] b);
    logic ok;
    case (p.code)
      MASK_EQ:      ok = (b == p.value);
      MASK_NE:      ok = (b != p.value);
      MASK_ZERO:    ok = (b == 8'h00);
      MASK_NONZERO: ok = (b != 8'h00);
      default:      ok = 1'b1;
    endcase
    return ok;
  endfunction

  // text of the xpm comment, slash star space XPM space star slash
  function automatic logic [7:0] xpm_char(logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = 8'h2F;
      4'd1:    c = 8'h2A;
      4'd2:    c = 8'h20;
      4'd3:    c = 8'h58;
      4'd4:    c = 8'h50;
      4'd5:    c = 8'h4D;
      4'd6:    c = 8'h20;
      4'd7:    c = 8'h2A;
      4'd8:    c = 8'h2F;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

/* rtl/msig_pattern_mem.sv */
// ----------------------------------------------------------------------------
// msig_pattern_mem
// Pattern byte store: one row per slot, written a byte at a time, read a row
// at a time with registered read data.
// ----------------------------------------------------------------------------
module msig_pattern_mem #(
  parameter int SLOTS           = msig_pkg::SLOTS_DEF,
  parameter int MAX_PATTERN_LEN = msig_pkg::MAX_PATTERN_LEN_DEF,
  localparam int SLOT_IW = (SLOTS > 1) ? $clog2(SLOTS) : 1,
  localparam int POS_IW  = (MAX_PATTERN_LEN > 1) ? $clog2(MAX_PATTERN_LEN) : 1
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [SLOT_IW-1:0]   wr_slot,
  input  logic [POS_IW-1:0]    wr_pos,
  input  msig_pkg::pat_entry_t wr_data,
  input  logic [SLOT_IW-1:0]   rd_slot,
  output msig_pkg::pat_entry_t rd_row [MAX_PATTERN_LEN]
);

  msig_pkg::pat_entry_t mem [SLOTS][MAX_PATTERN_LEN];

  // byte-lane write, whole-row registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_slot][wr_pos] <= wr_data;
    end
    rd_row <= mem[rd_slot];
  end

endmodule

/* rtl/msig_match_unit.sv */
// ----------------------------------------------------------------------------
// msig_match_unit
// Shared slot compare: checks one slot's masked pattern against the newest
// bytes of the window and decides whether the slot matches now.
// ----------------------------------------------------------------------------
module msig_match_unit #(
  parameter int MAX_PATTERN_LEN = msig_pkg::MAX_PATTERN_LEN_DEF,
  parameter int CB_W            = 5,
  localparam int LEN_W  = $clog2(MAX_PATTERN_LEN + 1),
  localparam int WIN_IW = (MAX_PATTERN_LEN > 1) ? $clog2(MAX_PATTERN_LEN) : 1
) (
  input  msig_pkg::slot_hdr_t  hdr,
  input  logic [LEN_W-1:0]     len,
  input  logic                 matched,
  input  logic [CB_W-1:0]      prev_count,
  input  msig_pkg::pat_entry_t row [MAX_PATTERN_LEN],
  input  logic [7:0]           window [MAX_PATTERN_LEN],
  output logic                 hit
);

  logic [MAX_PATTERN_LEN-1:0] lane_ok;
  logic                       all_ok;
  logic                       place_ok;
  logic [CB_W:0]              prev_ext;
  logic [CB_W:0]              len_ext;

  // pattern byte j lines up with window byte len-1-j
  always_comb begin
    logic [LEN_W-1:0] widx;
    for (int j = 0; j < MAX_PATTERN_LEN; j++) begin
      widx = len - LEN_W'(1) - LEN_W'(j);
      if (LEN_W'(j) < len) begin
        lane_ok[j] = msig_pkg::byte_ok(row[j], window[widx[WIN_IW-1:0]]);
      end else begin
        lane_ok[j] = 1'b1;
      end
    end
  end

  assign all_ok   = &lane_ok;
  assign prev_ext = (CB_W + 1)'(prev_count);
  assign len_ext  = (CB_W + 1)'(len);

  // anchored needs the pattern to end on this byte from offset zero
  always_comb begin
    if (hdr.anch) begin
      place_ok = (prev_ext + (CB_W + 1)'(1) == len_ext);
    end else begin
      place_ok = (prev_ext + (CB_W + 1)'(1) >= len_ext);
    end
  end

  assign hit = hdr.en && !matched && ((len == '0) || (place_ok && all_ok));

endmodule

/* rtl/msig_score_rank.sv */
// ----------------------------------------------------------------------------
// msig_score_rank
// Per-format score store and ranking: keeps the first matching slot's
// relevance for each format, then walks the formats to pick the winner.
// ----------------------------------------------------------------------------
module msig_score_rank #(
  parameter int FORMATS = msig_pkg::FORMATS_DEF,
  localparam int FMT_IW = (FORMATS > 1) ? $clog2(FORMATS) : 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  msig_pkg::score_ctl_t ctl,
  input  logic [FMT_IW-1:0]    rank_idx,
  output logic [6:0]           best_score,
  output logic [3:0]           best_format
);

  logic [FORMATS-1:0] taken;
  logic [6:0]         scores [FORMATS];
  logic [FMT_IW-1:0]  rec_idx;
  logic               rec_ok;
  logic [6:0]         rd_score;
  logic [FMT_IW-1:0]  rd_fmt;
  logic               rd_vld;
  logic               stop;
  logic [FMT_IW-1:0]  sel;

  assign rec_idx = FMT_IW'(ctl.rec_fmt);
  assign rec_ok  = ctl.rec && (32'(ctl.rec_fmt) < FORMATS) && !taken[rec_idx];

  // first matching slot of a format sets its score
  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      taken <= '0;
    end else if (rec_ok) begin
      taken[rec_idx] <= 1'b1;
    end
  end

  // score values and registered ranking read
  always_ff @(posedge clk) begin
    if (rec_ok) begin
      scores[rec_idx] <= ctl.rec_rel;
    end
    rd_score <= taken[rank_idx] ? scores[rank_idx] : 7'd0;
    rd_fmt   <= rank_idx;
  end

  // running best, lowest format wins ties, a perfect score ends the walk
  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      rd_vld     <= 1'b0;
      stop       <= 1'b0;
      best_score <= 7'd0;
      sel        <= '0;
    end else begin
      rd_vld <= ctl.rank_rd;
      if (rd_vld && !stop) begin
        if (rd_score > best_score) begin
          best_score <= rd_score;
          sel        <= rd_fmt;
        end
        if (rd_score >= msig_pkg::PERFECT_SCORE) begin
          stop <= 1'b1;
        end
      end
    end
  end

  assign best_format = 4'(sel);

endmodule

/* rtl/masked_signature_sniffer_top.sv */
// ----------------------------------------------------------------------------
// masked_signature_sniffer_top
// Masked magic-signature sniffer with a loadable slot table.
// ----------------------------------------------------------------------------
// Usage:
//   One input channel (in_valid / in_ready) carries three kinds of transfer:
//   pattern byte writes (mode 0), slot header writes (mode 1) and buffer
//   bytes (mode 2, last on the final byte). Mode 3 is dropped.
//   Table writes may come back to back.
//   A buffer byte runs one pass over the slot table through the shared
//   compare unit, one slot per cycle from the pattern row memory; the
//   input is not ready for the next byte until that pass is done.
//   On the last byte a ranking pass over the formats follows, and then the
//   result appears on the output channel (out_valid / out_ready). Each
//   buffer gives exactly one result.
//   The result sits in an output register. A stalled receiver holds the
//   block only when the next result is ready to be loaded.
//   Reset disables all slots and clears the buffer state; pattern bytes are
//   not cleared and must be written before a slot that reads them is enabled.
// ----------------------------------------------------------------------------
module masked_signature_sniffer_top #(
  parameter int SLOTS           = msig_pkg::SLOTS_DEF,
  parameter int MAX_PATTERN_LEN = msig_pkg::MAX_PATTERN_LEN_DEF,
  parameter int FORMATS         = msig_pkg::FORMATS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] mode,
  input  logic [3:0] slot,
  input  logic [3:0] position,
  input  logic [7:0] byte_value,
  input  logic [2:0] mask_code,
  input  logic [4:0] pattern_length,
  input  logic       anchored,
  input  logic [6:0] relevance,
  input  logic [3:0] format_id,
  input  logic       slot_enable,
  input  logic       last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       found,
  output logic [3:0] best_format,
  output logic [6:0] best_score,
  output logic       xpm_header
);

  localparam int SLOT_IW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int POS_IW    = (MAX_PATTERN_LEN > 1) ? $clog2(MAX_PATTERN_LEN) : 1;
  localparam int FMT_IW    = (FORMATS > 1) ? $clog2(FORMATS) : 1;
  localparam int LEN_W     = $clog2(MAX_PATTERN_LEN + 1);
  localparam int COUNT_CAP = (MAX_PATTERN_LEN > 16) ? MAX_PATTERN_LEN : 16;
  localparam int CB_W      = $clog2(COUNT_CAP + 1);
  localparam int CNT_W     = $clog2(((SLOTS > FORMATS) ? SLOTS : FORMATS) + 1);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_MATCH = 4'b0010,
    ST_RANK  = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  state_t                state;
  logic [CNT_W-1:0]      cnt;
  logic                  last_buf;
  logic [SLOT_IW-1:0]    eval_slot;
  logic [SLOT_IW-1:0]    rd_slot;
  msig_pkg::slot_hdr_t   hdr [SLOTS];
  logic [LEN_W-1:0]      hdr_len [SLOTS];
  logic [7:0]            window [MAX_PATTERN_LEN];
  logic [SLOTS-1:0]      matched;
  logic [CB_W-1:0]       byte_count;
  logic [CB_W-1:0]       prev_count;
  logic                  xpm_ok;
  msig_pkg::pat_entry_t  row [MAX_PATTERN_LEN];
  msig_pkg::slot_hdr_t   cur_hdr;
  logic                  hit;
  logic                  in_fire;
  logic                  data_fire;
  logic                  pat_we;
  logic                  hdr_we;
  logic                  eval_en;
  logic                  out_load;
  msig_pkg::score_ctl_t  sctl;
  logic [6:0]            rank_score;
  logic [3:0]            rank_format;

  assign in_ready  = (state == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign data_fire = in_fire && (mode == msig_pkg::MODE_DATA);
  assign pat_we    = in_fire && (mode == msig_pkg::MODE_PAT) && (32'(slot) < SLOTS)
                     && (32'(position) < MAX_PATTERN_LEN);
  assign hdr_we    = in_fire && (mode == msig_pkg::MODE_HDR) && (32'(slot) < SLOTS);
  assign eval_en   = (state == ST_MATCH) && (cnt != '0);
  assign out_load  = (state == ST_DONE) && (!out_valid || out_ready);
  assign rd_slot   = (32'(cnt) < SLOTS) ? cnt[SLOT_IW-1:0] : '0;

  // sequencer: slot pass per byte, format pass after the last byte
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      cnt      <= '0;
      last_buf <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (data_fire) begin
            state    <= ST_MATCH;
            cnt      <= '0;
            last_buf <= last;
          end
        end
        ST_MATCH: begin
          if (cnt == CNT_W'(SLOTS)) begin
            cnt   <= '0;
            state <= last_buf ? ST_RANK : ST_IDLE;
          end else begin
            cnt <= cnt + CNT_W'(1);
          end
        end
        ST_RANK: begin
          if (cnt == CNT_W'(FORMATS)) begin
            cnt   <= '0;
            state <= ST_DONE;
          end else begin
            cnt <= cnt + CNT_W'(1);
          end
        end
        ST_DONE: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // slot headers, all disabled at reset, length clamped on write
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        hdr[i]     <= '0;
        hdr_len[i] <= '0;
      end
    end else if (hdr_we) begin
      hdr[SLOT_IW'(slot)] <= '{en: slot_enable, fmt: format_id, rel: relevance,
                               anch: anchored};
      if (32'(pattern_length) > MAX_PATTERN_LEN) begin
        hdr_len[SLOT_IW'(slot)] <= LEN_W'(MAX_PATTERN_LEN);
      end else begin
        hdr_len[SLOT_IW'(slot)] <= LEN_W'(pattern_length);
      end
    end
  end

  msig_pattern_mem #(
    .SLOTS           (SLOTS),
    .MAX_PATTERN_LEN (MAX_PATTERN_LEN)
  ) u_pat_mem (
    .clk     (clk),
    .we      (pat_we),
    .wr_slot (SLOT_IW'(slot)),
    .wr_pos  (POS_IW'(position)),
    .wr_data ('{code: mask_code, value: byte_value}),
    .rd_slot (rd_slot),
    .rd_row  (row)
  );

  // slot under compare is the registered row read address, in step with the registered row
  always_ff @(posedge clk) begin
    eval_slot <= rd_slot;
  end

  // byte window, count, xpm prefix tracking
  always_ff @(posedge clk) begin
    if (rst || out_load) begin
      for (int i = 0; i < MAX_PATTERN_LEN; i++) begin
        window[i] <= 8'h00;
      end
      byte_count <= '0;
      prev_count <= '0;
      xpm_ok     <= 1'b1;
    end else if (data_fire) begin
      window[0] <= byte_value;
      for (int i = 1; i < MAX_PATTERN_LEN; i++) begin
        window[i] <= window[i-1];
      end
      prev_count <= byte_count;
      if (byte_count != CB_W'(COUNT_CAP)) begin
        byte_count <= byte_count + CB_W'(1);
      end
      if ((32'(byte_count) < msig_pkg::XPM_LEN)
          && (byte_value != msig_pkg::xpm_char(byte_count[3:0]))) begin
        xpm_ok <= 1'b0;
      end
    end
  end

  assign cur_hdr = hdr[eval_slot];

  msig_match_unit #(
    .MAX_PATTERN_LEN (MAX_PATTERN_LEN),
    .CB_W            (CB_W)
  ) u_match (
    .hdr        (cur_hdr),
    .len        (hdr_len[eval_slot]),
    .matched    (matched[eval_slot]),
    .prev_count (prev_count),
    .row        (row),
    .window     (window),
    .hit        (hit)
  );

  // sticky match flags per slot
  always_ff @(posedge clk) begin
    if (rst || out_load) begin
      matched <= '0;
    end else if (eval_en && hit) begin
      matched[eval_slot] <= 1'b1;
    end
  end

  // scores are recorded in slot order during the final slot pass
  always_comb begin
    sctl.clear   = out_load;
    sctl.rec     = eval_en && last_buf && cur_hdr.en && (matched[eval_slot] || hit);
    sctl.rec_fmt = cur_hdr.fmt;
    sctl.rec_rel = cur_hdr.rel;
    sctl.rank_rd = (state == ST_RANK) && (32'(cnt) < FORMATS);
  end

  msig_score_rank #(
    .FORMATS (FORMATS)
  ) u_rank (
    .clk         (clk),
    .rst         (rst),
    .ctl         (sctl),
    .rank_idx    (cnt[FMT_IW-1:0]),
    .best_score  (rank_score),
    .best_format (rank_format)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      found       <= (rank_score != 7'd0);
      best_format <= (rank_score != 7'd0) ? rank_format : 4'd0;
      best_score  <= rank_score;
      xpm_header  <= xpm_ok && (32'(byte_count) > msig_pkg::XPM_LEN);
    end
  end

endmodule

/* rtl/msig_checker.sv */
// ----------------------------------------------------------------------------
// msig_port_assert
// Port-level checks for the masked signature sniffer, bound to the top level.
// ----------------------------------------------------------------------------
module msig_port_assert (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic [1:0] mode,
  input logic       last,
  input logic       out_valid,
  input logic       out_ready,
  input logic       found,
  input logic [3:0] best_format,
  input logic [6:0] best_score
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // found agrees with the score, and an empty result names no format
  a_found_score: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (found == (best_score != 7'd0)) && (found || best_format == 4'd0))
    else $error("found flag inconsistent with score");

  // a table write leaves the input free for the next transfer
  a_write_ready: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (mode == msig_pkg::MODE_PAT || mode == msig_pkg::MODE_HDR)
    |=> in_ready)
    else $error("input stalled after table write");

  // the last byte of a buffer takes the input out of ready as the slot pass starts
  a_data_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && mode == msig_pkg::MODE_DATA && last |=> !in_ready)
    else $error("input ready during slot pass");

endmodule

bind masked_signature_sniffer_top msig_port_assert u_msig_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .mode        (mode),
  .last        (last),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .found       (found),
  .best_format (best_format),
  .best_score  (best_score)
);
